// File: hdl/nrm2_pkg.sv
// Shared widths and constants for the vector L2 norm block.
package nrm2_pkg;

  // Input sample width (signed, SAMPLE_BITS-1 fraction bits)
  localparam int SAMPLE_BITS = 16;
  // Magnitude of a sample, including the most negative one
  localparam int MAG_BITS    = SAMPLE_BITS + 1;
  // Exact square of a magnitude
  localparam int SQ_BITS     = 2 * MAG_BITS;
  // Accumulator width, saturating
  localparam int SUM_BITS    = 47;
  // Norm width: floor(sqrt(2^SUM_BITS - 1)) fits here
  localparam int NORM_BITS   = 24;
  // Radicand padded to an even number of bits
  localparam int RAD_BITS    = 2 * NORM_BITS;
  // Partial remainder of the digit-by-digit root
  localparam int REM_BITS    = NORM_BITS + 2;
  // Step counter width for NORM_BITS root steps
  localparam int CNT_BITS    = $clog2(NORM_BITS);

  localparam logic [SUM_BITS-1:0] SUM_MAX = {SUM_BITS{1'b1}};

endpackage

// File: hdl/nrm2_in_if.sv
// Input channel: one vector element per word.
interface nrm2_in_if
  import nrm2_pkg::*;
;
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          last;

  modport source (output valid, output sample, output last, input ready);
  modport sink   (input valid, input sample, input last, output ready);
endinterface

// File: hdl/nrm2_out_if.sv
// Result channel: one norm word per vector.
interface nrm2_out_if
  import nrm2_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [NORM_BITS-1:0] norm;
  logic                 overflow;

  modport source (output valid, output norm, output overflow, input ready);
  modport sink   (input valid, input norm, input overflow, output ready);
endinterface

// File: hdl/vector_l2_norm_sum_of_squares.sv
// Top level: streaming Euclidean norm with a shared multiplier, adder and root stepper.
//
//  channel   dir  payload                         handshake
//  in_chan   in   sample[15:0] signed, last       valid/ready
//  out_chan  out  norm[23:0], overflow            valid/ready
//
//  Each element passes through three steps: accept, square, accumulate.
//  The last element adds 24 root steps, then a load of the output register.
//  The root loop (one result bit per cycle) sets the length of the last word.
//  The result sits in an output register; the next vector is accepted while it waits.
//  A stalled output only holds the block in its final load cycle if the register is full.
//  Reset (synchronous, rst_n low) clears the accumulator, overflow flag and control.
module vector_l2_norm_sum_of_squares
  import nrm2_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  nrm2_in_if.sink      in_chan,
  nrm2_out_if.source   out_chan
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MUL  = 5'b00010,
    S_ACC  = 5'b00100,
    S_ROOT = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t                        state_r, state_nxt;
  logic signed [SAMPLE_BITS-1:0] sample_r;
  logic                          last_r;
  logic [SQ_BITS-1:0]            sq_r;
  logic [SUM_BITS-1:0]           sum_r, sum_nxt;
  logic                          sat_r, sat_nxt;
  logic [RAD_BITS-1:0]           rad_r;
  logic [REM_BITS-1:0]           rem_r;
  logic [NORM_BITS-1:0]          root_r;
  logic [CNT_BITS-1:0]           cnt_r;
  logic                          ovf_r;
  logic                          out_valid_r;
  logic [NORM_BITS-1:0]          norm_r;
  logic                          overflow_r;

  logic [MAG_BITS-1:0]           ext;
  logic [MAG_BITS-1:0]           mag;
  logic [SUM_BITS:0]             sum_add;
  logic [REM_BITS-1:0]           rem_sh;
  logic [REM_BITS-1:0]           trial;
  logic                          take;
  logic                          out_load;
  logic                          root_done;

  assign take      = in_chan.valid && in_chan.ready;
  assign root_done = (cnt_r == CNT_BITS'(NORM_BITS - 1));
  assign out_load  = (state_r == S_DONE) && (!out_valid_r || out_chan.ready);

  assign in_chan.ready     = (state_r == S_IDLE);
  assign out_chan.valid    = out_valid_r;
  assign out_chan.norm     = norm_r;
  assign out_chan.overflow = overflow_r;

  // Sample magnitude, exact for the most negative code
  always_comb begin
    ext = {sample_r[SAMPLE_BITS-1], sample_r};
    mag = ext[MAG_BITS-1] ? MAG_BITS'(~ext + MAG_BITS'(1)) : ext;
  end

  // Saturating accumulate
  always_comb begin
    sum_add = {1'b0, sum_r} + (SUM_BITS+1)'(sq_r);
    if (sum_add[SUM_BITS]) begin
      sum_nxt = SUM_MAX;
      sat_nxt = 1'b1;
    end else begin
      sum_nxt = sum_add[SUM_BITS-1:0];
      sat_nxt = sat_r;
    end
  end

  // One root step: bring down two radicand bits, try root*4+1
  always_comb begin
    rem_sh = {rem_r[REM_BITS-3:0], rad_r[RAD_BITS-1 -: 2]};
    trial  = {root_r, 2'b01};
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (take) state_nxt = S_MUL;
      S_MUL:  state_nxt = S_ACC;
      S_ACC:  state_nxt = last_r ? S_ROOT : S_IDLE;
      S_ROOT: if (root_done) state_nxt = S_DONE;
      S_DONE: if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      sum_r   <= '0;
      sat_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_ACC) begin
        // last word: hand the total to the root and clear for the next vector
        sum_r <= last_r ? '0 : sum_nxt;
        sat_r <= last_r ? 1'b0 : sat_nxt;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (take) begin
      sample_r <= in_chan.sample;
      last_r   <= in_chan.last;
    end
    if (state_r == S_MUL) begin
      sq_r <= mag * mag;
    end
    if (state_r == S_ACC) begin
      rad_r  <= {{(RAD_BITS-SUM_BITS){1'b0}}, sum_nxt};
      rem_r  <= '0;
      root_r <= '0;
      cnt_r  <= '0;
      ovf_r  <= sat_nxt;
    end
    if (state_r == S_ROOT) begin
      rad_r <= {rad_r[RAD_BITS-3:0], 2'b00};
      cnt_r <= cnt_r + CNT_BITS'(1);
      if (rem_sh >= trial) begin
        rem_r  <= rem_sh - trial;
        root_r <= {root_r[NORM_BITS-2:0], 1'b1};
      end else begin
        rem_r  <= rem_sh;
        root_r <= {root_r[NORM_BITS-2:0], 1'b0};
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      norm_r     <= root_r;
      overflow_r <= ovf_r;
    end
  end

endmodule

// File: hdl/nrm2_chk.sv
// Port-level checker for the vector L2 norm block, with its bind.
module nrm2_chk
  import nrm2_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 in_last,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [NORM_BITS-1:0] norm,
  input logic                 overflow
);

  // A held result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // A held result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(norm) && $stable(overflow))
    else $error("result changed while stalled");

  // Block is busy right after taking a word
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted two words back to back");

  // A middle element never produces a result soon after it
  a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_last |=> !$rose(out_valid) ##1 !$rose(out_valid))
    else $error("result without a last element");

endmodule

bind vector_l2_norm_sum_of_squares nrm2_chk u_nrm2_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .in_last   (in_chan.last),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .norm      (out_chan.norm),
  .overflow  (out_chan.overflow)
);

// File: verif/vector_l2_norm_sum_of_squares_test.sv
// Testbench for the streaming L2 norm: directed table, then random vectors.
`timescale 1ns / 1ps

module vector_l2_norm_sum_of_squares_test;
  import nrm2_pkg::*;

  localparam int CYCLE_LIMIT    = 200_000;
  localparam int RANDOM_ITEMS   = 500;
  localparam int DIRECTED_COUNT = 21;
  localparam int TAIL_CYCLES    = 40;
  localparam int REPORT_LIMIT   = 10;

  // One result word: norm plus sticky overflow
  typedef struct packed {
    logic [NORM_BITS-1:0] norm;
    logic                 overflow;
  } norm_word_t;

  // One stimulus row; typed rows carry the result they must produce
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          last;
    logic                          typed;
    logic [NORM_BITS-1:0]          norm;
    logic                          overflow;
  } stim_row_t;

  logic clk;
  logic rst_n;

  nrm2_in_if  in_chan ();
  nrm2_out_if out_chan ();

  vector_l2_norm_sum_of_squares i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // Running state of the predictor
  logic [SUM_BITS-1:0] accum_sum;
  logic                accum_sat;
  norm_word_t          pending_norms [$];
  norm_word_t          got_word;
  norm_word_t          want_word;

  int cycle_count;
  int error_count;
  int elements_sent;
  int words_checked;
  int overflow_words;
  int burst_left;
  int random_items;
  int vec_len;

  logic [15:0] stall_pattern = 16'hFFFF;
  logic [5:0]  stall_phase   = '0;

  // Directed rows: reset state, extremes, sign handling, floor rounding, zero vector
  stim_row_t directed_rows [DIRECTED_COUNT] = '{
    '{16'sh0000, 1'b1, 1'b1, 24'd0,     1'b0},
    '{16'sh7FFF, 1'b1, 1'b1, 24'd32767, 1'b0},
    '{16'sh8000, 1'b1, 1'b1, 24'd32768, 1'b0},
    '{16'sh0001, 1'b1, 1'b1, 24'd1,     1'b0},
    '{16'shFFFF, 1'b1, 1'b1, 24'd1,     1'b0},
    '{16'sh0003, 1'b0, 1'b0, 24'd0,     1'b0},
    '{16'shFFFC, 1'b1, 1'b1, 24'd5,     1'b0},
    '{16'sh8000, 1'b0, 1'b0, 24'd0,     1'b0},
    '{16'sh8000, 1'b0, 1'b0, 24'd0,     1'b0},
    '{16'sh8000, 1'b0, 1'b0, 24'd0,     1'b0},
    '{16'sh8000, 1'b1, 1'b1, 24'd65536, 1'b0},
    '{16'sh0002, 1'b0, 1'b0, 24'd0,     1'b0},
    '{16'sh0002, 1'b1, 1'b1, 24'd2,     1'b0},
    '{16'sh5555, 1'b0, 1'b0, 24'd0,     1'b0},
    '{16'shAAAA, 1'b0, 1'b0, 24'd0,     1'b0},
    '{16'sh7FFF, 1'b0, 1'b0, 24'd0,     1'b0},
    '{16'sh8001, 1'b1, 1'b0, 24'd0,     1'b0},
    '{16'sh0000, 1'b0, 1'b0, 24'd0,     1'b0},
    '{16'sh0000, 1'b0, 1'b0, 24'd0,     1'b0},
    '{16'sh0000, 1'b1, 1'b1, 24'd0,     1'b0},
    '{16'sh00FF, 1'b1, 1'b1, 24'd255,   1'b0}
  };

  // Clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Largest r with r*r <= x, one result bit per pass from the top
  function automatic logic [NORM_BITS-1:0] floor_root(input logic [SUM_BITS-1:0] x);
    logic [NORM_BITS-1:0] root;
    logic [NORM_BITS-1:0] trial;
    root = '0;
    for (int b = NORM_BITS - 1; b >= 0; b--) begin
      trial = root | (NORM_BITS'(1) << b);
      if (64'(trial) * 64'(trial) <= 64'(x)) root = trial;
    end
    return root;
  endfunction

  // Adds one element's square; returns 1 with the norm word when the vector closes
  function automatic bit fold_sample(input logic signed [SAMPLE_BITS-1:0] s,
                                     input logic is_last, output norm_word_t w);
    logic [MAG_BITS-1:0] mag;
    logic [SQ_BITS-1:0]  sq;
    w   = '0;
    mag = (s < 0) ? MAG_BITS'(-int'(s)) : MAG_BITS'(s);
    sq  = SQ_BITS'(mag) * SQ_BITS'(mag);
    if (SUM_BITS'(sq) > SUM_MAX - accum_sum) begin
      accum_sum = SUM_MAX;
      accum_sat = 1'b1;
    end else begin
      accum_sum = accum_sum + SUM_BITS'(sq);
    end
    if (!is_last) return 1'b0;
    w.norm     = floor_root(accum_sum);
    w.overflow = accum_sat;
    accum_sum  = '0;
    accum_sat  = 1'b0;
    return 1'b1;
  endfunction

  task automatic flag_error(input string what, input longint want_v, input longint got_v);
    error_count++;
    if (error_count <= REPORT_LIMIT)
      $display("[%0t] ERROR %s: expected %0d, got %0d", $time, what, want_v, got_v);
  endtask

  // Offer one word and hold it until the block takes it
  task automatic send_element(input stim_row_t row);
    norm_word_t w;
    in_chan.valid  <= 1'b1;
    in_chan.sample <= row.sample;
    in_chan.last   <= row.last;
    do @(posedge clk); while (!in_chan.ready);
    elements_sent++;
    if (fold_sample(row.sample, row.last, w)) begin
      if (row.typed) begin
        w.norm     = row.norm;
        w.overflow = row.overflow;
      end
      pending_norms.push_back(w);
    end
  endtask

  // Bursts of random length; a gap of random length between bursts
  task automatic sender_pause();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 160)
                                               : $urandom_range(1, 10);
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_chan.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Random sample, weighted toward the extremes and small values
  function automatic stim_row_t random_row(input logic is_last);
    stim_row_t row;
    row = '0;
    row.last = is_last;
    case ($urandom_range(0, 9))
      0:       row.sample = 16'sh8000;
      1:       row.sample = 16'sh7FFF;
      2:       row.sample = 16'sh0000;
      3:       row.sample = SAMPLE_BITS'($urandom_range(0, 31)) - 16'sd16;
      default: row.sample = SAMPLE_BITS'($urandom);
    endcase
    return row;
  endfunction

  // Receiver: rotating stall pattern, reloaded when the 6-bit phase counter wraps, sometimes all-ready
  always @(posedge clk) begin
    stall_phase <= stall_phase + 6'd1;
    if (stall_phase == '0) begin
      stall_pattern <= ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
    end else begin
      stall_pattern <= {stall_pattern[14:0], stall_pattern[15]};
    end
    out_chan.ready <= stall_pattern[15];
  end

  // Result checker: each accepted word against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready) begin
      words_checked++;
      got_word.norm     = out_chan.norm;
      got_word.overflow = out_chan.overflow;
      if (got_word.overflow) overflow_words++;
      if (pending_norms.size() == 0) begin
        flag_error("result word with nothing pending (norm)", -1, got_word.norm);
      end else begin
        want_word = pending_norms.pop_front();
        if (got_word.norm !== want_word.norm)
          flag_error("norm", want_word.norm, got_word.norm);
        if (got_word.overflow !== want_word.overflow)
          flag_error("overflow", want_word.overflow, got_word.overflow);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d words still pending",
               cycle_count, pending_norms.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Main sequence
  initial begin
    accum_sum      = '0;
    accum_sat      = 1'b0;
    elements_sent  = 0;
    burst_left     = 0;
    random_items   = 0;
    rst_n          <= 1'b0;
    in_chan.valid  <= 1'b0;
    in_chan.sample <= '0;
    in_chan.last   <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table
    for (int i = 0; i < DIRECTED_COUNT; i++) begin
      send_element(directed_rows[i]);
      sender_pause();
    end

    // Random vectors, mostly short, a few long
    while (random_items < RANDOM_ITEMS) begin
      vec_len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 48) : $urandom_range(1, 8);
      for (int k = 1; k <= vec_len; k++) begin
        send_element(random_row(k == vec_len));
        random_items++;
        sender_pause();
      end
    end
    in_chan.valid <= 1'b0;

    // Drain, then allow for a root in flight
    while (pending_norms.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d elements (%0d random); checked %0d norm words, %0d with overflow.",
             elements_sent, random_items, words_checked, overflow_words);
    $display("Mismatches: %0d in %0d cycles.", error_count, cycle_count);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
